[hw/rtl/least_loaded_connection_picker_macros.svh]
// Assertion macros for the least-loaded connection picker.
`ifndef LEAST_LOADED_CONNECTION_PICKER_MACROS_SVH
`define LEAST_LOADED_CONNECTION_PICKER_MACROS_SVH

// Checked at every clock edge outside reset.
`define LLCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge outside reset, result checked in the cycle after the trigger.
`define LLCP_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

[hw/rtl/llcp_pkg.sv]
// Types and constants shared by the connection picker files.
`timescale 1ns / 1ps
`default_nettype none

package llcp_pkg;

  localparam int unsigned REQ_TYPE_W   = 2;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_LIMIT_W  = 5;
  localparam int unsigned CFG_LOAD_W   = 16;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_OPEN    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLOSE   = 2'd2,
    REQ_RSVD    = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_IGNORED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONN_LIMIT = 2'd0,
    CFG_MIN_LOAD   = 2'd1,
    CFG_MAX_LOAD   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/llcp_if.sv]
// Request and response channel interfaces of the connection picker.
`timescale 1ns / 1ps
`default_nettype none

interface llcp_req_if;
  import llcp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [SLOT_W-1:0]     slot_in;

  modport source (output valid, output req_type, output slot_in, input ready);
  modport sink (input valid, input req_type, input slot_in, output ready);
endinterface

interface llcp_rsp_if;
  import llcp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic                fresh_slot;
  logic                at_capacity;

  modport source (output valid, output status, output slot_out, output fresh_slot,
                  output at_capacity, input ready);
  modport sink (input valid, input status, input slot_out, input fresh_slot,
                input at_capacity, output ready);
endinterface

`default_nettype wire

[hw/rtl/llcp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module llcp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/least_loaded_connection_picker.sv]
// Least-loaded connection picker: slot stream counts in RAM, scanned per open request.
`timescale 1ns / 1ps
`default_nettype none

// Stream counts live in one RAM with one read and one write port; the number of slots
// in use acts as a fill count, so no clearing pass follows reset or close. One request
// is handled at a time. An open on a non-empty, open pool scans the slots in use: the
// RAM read port delivers one slot count per cycle to the minimum search, then the finish
// state decides and writes back. Every other request goes from idle straight to the
// finish state. A result waits in an output register, and the next request is accepted
// while it waits. Configuration may be written at any time the block is idle.

`include "least_loaded_connection_picker_macros.svh"

module least_loaded_connection_picker #(
  parameter int unsigned POOL_SLOTS = 16,
  parameter int unsigned LOAD_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [llcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [llcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  llcp_req_if.sink                        req_i,
  llcp_rsp_if.source                      rsp_o
);
  import llcp_pkg::*;

  localparam int unsigned AW   = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CNTW = $clog2(POOL_SLOTS + 1);
  localparam int unsigned IW   = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int unsigned CW   = (CNTW > SLOT_W) ? CNTW : SLOT_W;
  localparam int unsigned KW   = (CNTW > CFG_LIMIT_W) ? CNTW : CFG_LIMIT_W;
  localparam int unsigned LCW  = (LOAD_BITS > CFG_LOAD_W) ? LOAD_BITS : CFG_LOAD_W;
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

  state_e state_q, state_d;

  logic [CFG_LIMIT_W-1:0] limit_q;
  logic [CFG_LOAD_W-1:0]  min_q, max_q;

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            closed_q, closed_d;

  logic [REQ_TYPE_W-1:0] req_q, req_d;
  logic [SLOT_W-1:0]     sin_q, sin_d;

  logic [CNTW-1:0]      ptr_q, ptr_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic [AW-1:0]        best_q, best_d;
  logic [LOAD_BITS-1:0] best_load_q, best_load_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic                out_fresh_q, out_fresh_d;
  logic                out_full_q, out_full_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [LOAD_BITS-1:0] ram_wdata, ram_rdata;

  logic                 in_xfer, out_free, rel_hit_in, rel_hit_q;
  logic [AW-1:0]        sin_addr_in, sin_addr_q;
  logic [IW-1:0]        sin_ext_in, sin_ext_q, best_ext, new_ext;
  logic [KW-1:0]        eff_limit;
  logic                 reuse, pool_full;
  logic [LOAD_BITS-1:0] bumped;

  llcp_ram #(
    .WIDTH (LOAD_BITS),
    .DEPTH (POOL_SLOTS)
  ) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign in_xfer     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign sin_ext_in  = IW'(req_i.slot_in);
  assign sin_addr_in = sin_ext_in[AW-1:0];
  assign rel_hit_in  = CW'(req_i.slot_in) < CW'(cnt_q);
  assign sin_ext_q   = IW'(sin_q);
  assign sin_addr_q  = sin_ext_q[AW-1:0];
  assign rel_hit_q   = CW'(sin_q) < CW'(cnt_q);

  assign best_ext = IW'(best_q);
  assign new_ext  = IW'(cnt_q[AW-1:0]);

  always_comb begin
    eff_limit = KW'(limit_q);
    if (limit_q == '0 && min_q == '0 && max_q == '0) begin
      eff_limit = KW'(1);
    end
    if (best_load_q == '0) begin
      reuse = 1'b1;
    end else if (eff_limit != '0) begin
      reuse = (KW'(cnt_q) >= eff_limit) || (LCW'(best_load_q) < LCW'(min_q));
    end else begin
      reuse = (max_q != '0) && (LCW'(best_load_q) < LCW'(max_q));
    end
    pool_full = (cnt_q == CNTW'(POOL_SLOTS));
    bumped    = (best_load_q == LOAD_MAX) ? best_load_q : best_load_q + LOAD_BITS'(1);
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    closed_d     = closed_q;
    req_d        = req_q;
    sin_d        = sin_q;
    ptr_d        = ptr_q;
    rd_idx_d     = rd_idx_q;
    best_d       = best_q;
    best_load_d  = best_load_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_fresh_d  = out_fresh_q;
    out_full_d   = out_full_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          req_d   = req_i.req_type;
          sin_d   = req_i.slot_in;
          state_d = S_FINISH;
          if (req_i.req_type == REQ_OPEN && !closed_q && cnt_q != '0) begin
            ram_re   = 1'b1;
            ram_raddr = '0;
            rd_idx_d = '0;
            ptr_d    = CNTW'(1);
            state_d  = S_SCAN;
          end else if (req_i.req_type == REQ_RELEASE && rel_hit_in) begin
            ram_re    = 1'b1;
            ram_raddr = sin_addr_in;
          end
        end
      end
      S_SCAN: begin
        if (rd_idx_q == '0 || ram_rdata < best_load_q) begin
          best_d      = rd_idx_q;
          best_load_d = ram_rdata;
        end
        if (ptr_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[AW-1:0];
          rd_idx_d  = ptr_q[AW-1:0];
          ptr_d     = ptr_q + CNTW'(1);
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_DONE;
          out_slot_d   = '0;
          out_fresh_d  = 1'b0;
          out_full_d   = 1'b0;
          state_d      = S_IDLE;
          case (req_q)
            REQ_OPEN: begin
              if (closed_q) begin
                out_status_d = STAT_REFUSED;
              end else if (cnt_q == '0) begin
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = LOAD_BITS'(1);
                cnt_d       = CNTW'(1);
                out_fresh_d = 1'b1;
              end else if (!reuse && !pool_full) begin
                ram_we      = 1'b1;
                ram_waddr   = cnt_q[AW-1:0];
                ram_wdata   = LOAD_BITS'(1);
                cnt_d       = cnt_q + CNTW'(1);
                out_fresh_d = 1'b1;
                out_slot_d  = new_ext[SLOT_W-1:0];
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = best_q;
                ram_wdata  = bumped;
                out_full_d = !reuse;
                out_slot_d = best_ext[SLOT_W-1:0];
              end
            end
            REQ_RELEASE: begin
              if (rel_hit_q && ram_rdata != '0) begin
                ram_we    = 1'b1;
                ram_waddr = sin_addr_q;
                ram_wdata = ram_rdata - LOAD_BITS'(1);
              end else begin
                out_status_d = STAT_IGNORED;
              end
            end
            REQ_CLOSE: begin
              closed_d = 1'b1;
              cnt_d    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= CFG_LIMIT_W'(1);
      min_q       <= '0;
      max_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      closed_q    <= closed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CONN_LIMIT: limit_q <= cfg_data_i[CFG_LIMIT_W-1:0];
          CFG_MIN_LOAD:   min_q   <= cfg_data_i[CFG_LOAD_W-1:0];
          CFG_MAX_LOAD:   max_q   <= cfg_data_i[CFG_LOAD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    sin_q        <= sin_d;
    ptr_q        <= ptr_d;
    rd_idx_q     <= rd_idx_d;
    best_q       <= best_d;
    best_load_q  <= best_load_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_fresh_q  <= out_fresh_d;
    out_full_q   <= out_full_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.slot_out    = out_slot_q;
  assign rsp_o.fresh_slot  = out_fresh_q;
  assign rsp_o.at_capacity = out_full_q;

  `LLCP_ASSERT(a_cnt_bound, cnt_q <= CNTW'(POOL_SLOTS), "slot count above pool size")
  `LLCP_ASSERT(a_closed_empty, !closed_q || cnt_q == '0, "closed pool holds slots")
  `LLCP_ASSERT(a_scan_ptr, state_q != S_SCAN || (ptr_q <= cnt_q && ptr_q != '0),
               "scan pointer outside the pool")
  `LLCP_ASSERT_NEXT(a_finish_out, state_q == S_FINISH && out_free,
                    out_valid_q && state_q == S_IDLE, "finished request gave no result")

endmodule

`default_nettype wire

[test/tb_top.sv]
// Testbench for the least-loaded connection picker: predicted grants checked per transfer.
`timescale 1ns / 1ps

module tb_top;
  import llcp_pkg::*;

  localparam int unsigned POOL       = 16;
  localparam int unsigned QUIET_MAX  = 5000;
  localparam int unsigned DRAIN_WAIT = 40;
  localparam int unsigned PILE_OPENS = 20;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct packed {
    status_e    status;
    logic [3:0] slot;
    logic       fresh;
    logic       at_cap;
  } grant_t;

  class pool_tracker;
    logic [15:0] stream_cnt [POOL];
    int unsigned used_slots;
    bit          closed;
    logic [4:0]  conn_limit;
    logic [15:0] min_thr;
    logic [15:0] max_thr;
    grant_t      pending_grants [$];
    int unsigned errors;

    function new();
      foreach (stream_cnt[i]) stream_cnt[i] = '0;
      used_slots = 0;
      closed     = 1'b0;
      conn_limit = 5'd1;
      min_thr    = '0;
      max_thr    = '0;
      errors     = 0;
    endfunction

    task automatic report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function automatic void note_request(req_e rq, logic [3:0] sl);
      grant_t      g;
      int unsigned best;
      int unsigned lim;
      bit          reuse;
      g = '{STAT_DONE, 4'd0, 1'b0, 1'b0};
      case (rq)
        REQ_OPEN: begin
          if (closed) begin
            g.status = STAT_REFUSED;
          end else if (used_slots == 0) begin
            used_slots    = 1;
            stream_cnt[0] = 16'd1;
            g.fresh       = 1'b1;
          end else begin
            best = 0;
            for (int i = 1; i < used_slots; i++)
              if (stream_cnt[i] < stream_cnt[best]) best = i;
            lim = conn_limit;
            if (conn_limit == 0 && min_thr == 0 && max_thr == 0) lim = 1;
            if (stream_cnt[best] == 0) reuse = 1'b1;
            else if (lim > 0) reuse = (used_slots >= lim) || (stream_cnt[best] < min_thr);
            else reuse = (max_thr != 0) && (stream_cnt[best] < max_thr);
            if (!reuse && used_slots < POOL) begin
              best             = used_slots;
              used_slots       = used_slots + 1;
              stream_cnt[best] = '0;
              g.fresh          = 1'b1;
            end else if (!reuse) begin
              g.at_cap = 1'b1;
            end
            if (stream_cnt[best] != 16'hFFFF) stream_cnt[best] = stream_cnt[best] + 16'd1;
            g.slot = 4'(best);
          end
        end
        REQ_RELEASE: begin
          if (sl < used_slots && stream_cnt[sl] != 0) stream_cnt[sl] = stream_cnt[sl] - 16'd1;
          else g.status = STAT_IGNORED;
        end
        REQ_CLOSE: begin
          closed     = 1'b1;
          used_slots = 0;
          foreach (stream_cnt[i]) stream_cnt[i] = '0;
        end
        default: ;
      endcase
      pending_grants.insert(pending_grants.size(), g);
    endfunction

    task automatic check_result(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        report("response transfer with no request outstanding");
      end else begin
        want = pending_grants.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.slot !== want.slot)
          report($sformatf("slot_out got %0d want %0d", got.slot, want.slot));
        if (got.fresh !== want.fresh)
          report($sformatf("fresh_slot got %0b want %0b", got.fresh, want.fresh));
        if (got.at_cap !== want.at_cap)
          report($sformatf("at_capacity got %0b want %0b", got.at_cap, want.at_cap));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  llcp_req_if req_if ();
  llcp_rsp_if rsp_if ();

  least_loaded_connection_picker DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  pool_tracker tracker = new();
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;
  bit          hold_req   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfer monitors
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      tracker.note_request(req_e'(req_if.req_type), req_if.slot_in);
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      tracker.check_result('{status_e'(rsp_if.status), rsp_if.slot_out,
                             rsp_if.fresh_slot, rsp_if.at_capacity});
  end

  task automatic send_req(req_e rq, logic [3:0] sl);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    req_if.valid    <= 1'b1;
    req_if.req_type <= rq;
    req_if.slot_in  <= sl;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending_grants.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic [4:0] lim, logic [15:0] mn, logic [15:0] mx);
    drain();
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_CONN_LIMIT;
    cfg_data <= {11'd0, lim};
    @(negedge clk_i);
    cfg_idx  <= CFG_MIN_LOAD;
    cfg_data <= mn;
    @(negedge clk_i);
    cfg_idx  <= CFG_MAX_LOAD;
    cfg_data <= mx;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    tracker.conn_limit = lim;
    tracker.min_thr    = mn;
    tracker.max_thr    = mx;
  endtask

  task automatic random_req(int unsigned open_pct, bit allow_close);
    int unsigned r;
    logic [3:0]  sl;
    r = $urandom_range(0, 99);
    if (tracker.used_slots > 0 && $urandom_range(0, 4) != 0)
      sl = 4'($urandom_range(0, tracker.used_slots - 1));
    else
      sl = 4'($urandom_range(0, 15));
    if (allow_close && r < 8) send_req(REQ_CLOSE, sl);
    else if (r < open_pct) send_req(REQ_OPEN, 4'($urandom_range(0, 15)));
    else if (r < 96) send_req(REQ_RELEASE, sl);
    else send_req(REQ_RSVD, sl);
  endtask

  // receiver: stall pattern redrawn at random when each mode runs out, one long hold-off
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned cyc;
    int unsigned per;
    int unsigned on_len;
    bit          held;
    rsp_if.ready = 1'b0;
    mode_left = 0;
    cyc = 0;
    per = 1;
    on_len = 1;
    mode = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_req && !held) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 128);
          per       = $urandom_range(2, 9);
          on_len    = $urandom_range(1, per - 1);
        end
        mode_left--;
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= $urandom_range(0, 1);
          2: rsp_if.ready <= ($urandom_range(0, 5) == 0);
          default: rsp_if.ready <= ((cyc % per) < on_len);
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("least_loaded_connection_picker verification failed");
    $finish;
  end

  initial begin
    logic [4:0]  lim;
    logic [15:0] mn;
    logic [15:0] mx;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_CONN_LIMIT;
    cfg_data        = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_OPEN;
    req_if.slot_in  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset configuration, empty pool, zero counts, unused code
    send_req(REQ_RELEASE, 4'd0);
    send_req(REQ_RELEASE, 4'hF);
    send_req(REQ_RSVD, 4'hF);
    send_req(REQ_OPEN, 4'd0);
    send_req(REQ_OPEN, 4'hF);
    send_req(REQ_RELEASE, 4'd0);
    send_req(REQ_RELEASE, 4'd0);
    send_req(REQ_RELEASE, 4'd0);
    send_req(REQ_OPEN, 4'd0);
    send_req(REQ_RELEASE, 4'd1);

    // all registers zero acts as a limit of one
    set_config(5'd0, 16'd0, 16'd0);
    send_req(REQ_OPEN, 4'd0);
    send_req(REQ_OPEN, 4'd0);

    // pile opens onto slot 0 back to back
    gaps_on = 1'b0;
    repeat (PILE_OPENS) send_req(REQ_OPEN, 4'($urandom_range(0, 15)));
    send_req(REQ_RELEASE, 4'd0);
    send_req(REQ_OPEN, 4'd0);
    send_req(REQ_OPEN, 4'd0);
    gaps_on = 1'b1;

    set_config(5'd16, 16'd0, 16'd0);
    repeat (3) send_req(REQ_OPEN, 4'd0);
    set_config(5'd2, 16'hFFFF, 16'd0);
    send_req(REQ_OPEN, 4'd0);
    set_config(5'd31, 16'd5, 16'd0);
    send_req(REQ_OPEN, 4'd0);
    set_config(5'd0, 16'd0, 16'd2);
    repeat (3) send_req(REQ_OPEN, 4'd0);

    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: begin lim = 5'd16; mn = 16'd0;    mx = 16'd0;    end
        1: begin lim = 5'd31; mn = 16'hFFFF; mx = 16'hFFFF; end
        2: begin lim = 5'd0;  mn = 16'd0;    mx = 16'd3;    end
        3: begin lim = 5'd0;  mn = 16'd0;    mx = 16'hFFFF; end
        4: begin lim = 5'd0;  mn = 16'd0;    mx = 16'd0;    end
        5: begin lim = 5'd4;  mn = 16'd2;    mx = 16'd0;    end
        6: begin lim = 5'd0;  mn = 16'd7;    mx = 16'd0;    end
        7: begin lim = 5'd1;  mn = 16'd0;    mx = 16'd1;    end
        default: begin
          lim = 5'($urandom_range(0, 31));
          mn  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
          mx  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
        end
      endcase
      set_config(lim, mn, mx);
      if (ph == 2) hold_req = 1'b1;
      begin
        int unsigned open_pct;
        open_pct = $urandom_range(45, 75);
        repeat (60) random_req(open_pct, 1'b0);
      end
    end

    // final phase: close the pool, then everything after a close
    set_config(5'($urandom_range(0, 31)), 16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
    repeat (30) random_req(60, 1'b0);
    send_req(REQ_CLOSE, 4'($urandom_range(0, 15)));
    send_req(REQ_OPEN, 4'd0);
    send_req(REQ_RELEASE, 4'd0);
    repeat (25) random_req(50, 1'b1);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("least_loaded_connection_picker verification clean");
    end else begin
      $display("least_loaded_connection_picker verification failed");
    end
    $finish;
  end

endmodule
